@@ rtl/core/lca_pkg.sv @@
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types and constants for the bounded-board cellular automaton.
// ----------------------------------------------------------------------------
package lca_pkg;

  // Board geometry (square board, GRID_SIZE rows of GRID_SIZE cells)
  localparam int unsigned GRID_SIZE = 8;
  localparam int unsigned ROW_W     = GRID_SIZE;
  localparam int unsigned ROW_IDX_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

  // Fixed payload widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned CELLS_W  = 8;

  // Padded widths used to move between payload and board widths
  localparam int unsigned PAD_W     = (ROW_W > CELLS_W) ? ROW_W : CELLS_W;
  localparam int unsigned IDX_PAD_W = (ROW_IDX_W > IDX_W) ? ROW_IDX_W : IDX_W;
  localparam int unsigned CMP_W     = 7;

  // Neighbor count and rule thresholds
  localparam int unsigned NBR_W      = 4;
  localparam logic [NBR_W-1:0] SURVIVE_CNT = NBR_W'(2);
  localparam logic [NBR_W-1:0] BIRTH_CNT   = NBR_W'(3);

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2
  } opcode_e;

  typedef logic [ROW_W-1:0] row_t;

  // Command handed from the top level to the board
  typedef struct packed {
    logic                en;
    logic [OPCODE_W-1:0] opcode;
    logic [IDX_W-1:0]    row_index;
    logic [CELLS_W-1:0]  row_cells;
  } cmd_t;

endpackage

@@ rtl/core/lca_if.sv @@
// ----------------------------------------------------------------------------
// lca_cmd_if / lca_rsp_if
// Valid/ready channels for commands and row results.
// ----------------------------------------------------------------------------
interface lca_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [lca_pkg::OPCODE_W-1:0]     opcode;
  logic [lca_pkg::IDX_W-1:0]        row_index;
  logic [lca_pkg::CELLS_W-1:0]      row_cells;

  modport source (output valid, output opcode, output row_index, output row_cells,
                  input ready);
  modport sink   (input valid, input opcode, input row_index, input row_cells,
                  output ready);
endinterface

interface lca_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [lca_pkg::CELLS_W-1:0]      row_out;
  logic [lca_pkg::IDX_W-1:0]        row_number;

  modport source (output valid, output row_out, output row_number, input ready);
  modport sink   (input valid, input row_out, input row_number, output ready);
endinterface

@@ rtl/core/lca_row_lane.sv @@
// ----------------------------------------------------------------------------
// lca_row_lane
// Next-generation logic for one board row, from the rows above and below.
// ----------------------------------------------------------------------------
module lca_row_lane (
  input  lca_pkg::row_t up_i,
  input  lca_pkg::row_t mid_i,
  input  lca_pkg::row_t dn_i,
  output lca_pkg::row_t next_o
);

  logic [lca_pkg::ROW_W+1:0] up_p;
  logic [lca_pkg::ROW_W+1:0] mid_p;
  logic [lca_pkg::ROW_W+1:0] dn_p;

  // Dead cells beyond the left and right edges
  assign up_p  = {1'b0, up_i,  1'b0};
  assign mid_p = {1'b0, mid_i, 1'b0};
  assign dn_p  = {1'b0, dn_i,  1'b0};

  // Count the eight neighbors of each cell and apply the rule
  always_comb begin
    logic [lca_pkg::NBR_W-1:0] cnt;
    cnt    = '0;
    next_o = '0;
    for (int x = 0; x < lca_pkg::ROW_W; x++) begin
      cnt = lca_pkg::NBR_W'(up_p[x])  + lca_pkg::NBR_W'(up_p[x+1]) +
            lca_pkg::NBR_W'(up_p[x+2]) + lca_pkg::NBR_W'(mid_p[x]) +
            lca_pkg::NBR_W'(mid_p[x+2]) + lca_pkg::NBR_W'(dn_p[x]) +
            lca_pkg::NBR_W'(dn_p[x+1]) + lca_pkg::NBR_W'(dn_p[x+2]);
      next_o[x] = (cnt == lca_pkg::BIRTH_CNT) ||
                  (mid_i[x] && (cnt == lca_pkg::SURVIVE_CNT));
    end
  end

endmodule

@@ rtl/core/lca_board.sv @@
// ----------------------------------------------------------------------------
// lca_board
// Board storage, one update lane per row, and the merge that builds the
// next board and picks the addressed row.
// ----------------------------------------------------------------------------
module lca_board (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lca_pkg::cmd_t               cmd_i,
  output logic [lca_pkg::CELLS_W-1:0] row_o
);

  lca_pkg::row_t board_q [lca_pkg::GRID_SIZE];
  lca_pkg::row_t board_d [lca_pkg::GRID_SIZE];
  lca_pkg::row_t lane_next [lca_pkg::GRID_SIZE];

  logic [lca_pkg::IDX_PAD_W-1:0] idx_pad;
  logic [lca_pkg::ROW_IDX_W-1:0] idx;
  logic                          on_board;
  logic [lca_pkg::PAD_W-1:0]     load_pad;
  lca_pkg::row_t                 load_row;
  logic [lca_pkg::PAD_W-1:0]     out_pad;
  lca_pkg::opcode_e              op;

  // Row addressing and load data sized to the board
  assign idx_pad  = lca_pkg::IDX_PAD_W'(cmd_i.row_index);
  assign idx      = idx_pad[lca_pkg::ROW_IDX_W-1:0];
  assign on_board = lca_pkg::CMP_W'(cmd_i.row_index) < lca_pkg::CMP_W'(lca_pkg::GRID_SIZE);
  assign load_pad = lca_pkg::PAD_W'(cmd_i.row_cells);
  assign load_row = load_pad[lca_pkg::ROW_W-1:0];
  assign op       = lca_pkg::opcode_e'(cmd_i.opcode);

  // One lane per row; rows beyond the top and bottom edges are dead
  for (genvar y = 0; y < lca_pkg::GRID_SIZE; y++) begin : g_lane
    lca_pkg::row_t up_row;
    lca_pkg::row_t dn_row;
    if (y > 0) begin : g_up
      assign up_row = board_q[y-1];
    end else begin : g_up_edge
      assign up_row = '0;
    end
    if (y < lca_pkg::GRID_SIZE - 1) begin : g_dn
      assign dn_row = board_q[y+1];
    end else begin : g_dn_edge
      assign dn_row = '0;
    end
    lca_row_lane u_lane (
      .up_i   (up_row),
      .mid_i  (board_q[y]),
      .dn_i   (dn_row),
      .next_o (lane_next[y])
    );
  end

  // Merge: next board per command
  always_comb begin
    board_d = board_q;
    if (cmd_i.en) begin
      case (op)
        lca_pkg::OP_LOAD: begin
          if (on_board) begin
            board_d[idx] = load_row;
          end
        end
        lca_pkg::OP_STEP: begin
          board_d = lane_next;
        end
        default: begin
        end
      endcase
    end
  end

  // Addressed row after the command, shown as columns 0 to 7
  always_comb begin
    out_pad = '0;
    if (on_board) begin
      out_pad = lca_pkg::PAD_W'(board_d[idx]);
    end
    row_o = out_pad[lca_pkg::CELLS_W-1:0];
  end

  // Board state, all cells dead after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int y = 0; y < lca_pkg::GRID_SIZE; y++) begin
        board_q[y] <= '0;
      end
    end else if (cmd_i.en) begin
      board_q <= board_d;
    end
  end

endmodule

@@ rtl/core/life_cellular_automaton.sv @@
// The result of a command is on rsp_o in the cycle after its transaction.
// Throughput: one command per cycle; a generation updates every row at once,
//   one row lane each, so an advance costs no more than a load or a read.
// A command is taken while the result register is empty or being drained.
// Reset (rst_ni low, asynchronous) clears the board to all dead and empties
//   the result register.
// ----------------------------------------------------------------------------
// life_cellular_automaton
// Top level: command channel, board with row lanes, registered result.
// ----------------------------------------------------------------------------
module life_cellular_automaton (
  input  logic        clk_i,
  input  logic        rst_ni,
  lca_cmd_if.sink     cmd_i,
  lca_rsp_if.source   rsp_o
);

  logic                        cmd_fire;
  logic                        rsp_valid_q;
  logic [lca_pkg::CELLS_W-1:0] row_out_q;
  logic [lca_pkg::IDX_W-1:0]   row_number_q;
  logic [lca_pkg::CELLS_W-1:0] board_row;
  lca_pkg::cmd_t               cmd;

  // Accept while the result register is free or drains this cycle
  assign cmd_i.ready = !rsp_valid_q || rsp_o.ready;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;

  assign cmd.en        = cmd_fire;
  assign cmd.opcode    = cmd_i.opcode;
  assign cmd.row_index = cmd_i.row_index;
  assign cmd.row_cells = cmd_i.row_cells;

  lca_board u_board (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .row_o  (board_row)
  );

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded with each transaction
  always_ff @(posedge clk_i) begin
    if (cmd_fire) begin
      row_out_q    <= board_row;
      row_number_q <= cmd_i.row_index;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.row_out    = row_out_q;
  assign rsp_o.row_number = row_number_q;

endmodule
